FILE: design/slt_pkg.sv
// shared types, codes and constants for the sorted list table
// no dependencies
package slt_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int VALUE_W      = 32;
    localparam int POS_W        = 5;
    localparam int COUNT_W      = 5;

    typedef logic signed [VALUE_W-1:0] value_t;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_SEARCH = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        STS_DONE      = 2'd0,
        STS_NOT_FOUND = 2'd1,
        STS_FULL      = 2'd2,
        STS_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_APPLY
    } state_t;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic   capture;
        logic   do_insert;
        logic   do_delete;
        value_t operand;
    } cell_ctrl_t;

endpackage

FILE: design/slt_req_if.sv
// request channel: operation and operand
// depends on slt_pkg
interface slt_req_if;
    logic           valid;
    logic           ready;
    logic [1:0]     action;
    slt_pkg::value_t value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

FILE: design/slt_rsp_if.sv
// response channel: status, position and count
// depends on slt_pkg
interface slt_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  status;
    logic [slt_pkg::POS_W-1:0]   position;
    logic [slt_pkg::COUNT_W-1:0] entry_count;

    modport source (output valid, output status, output position, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input position, input entry_count,
                    output ready);
endinterface

FILE: design/slt_cell.sv
// one slot of the ordered table: value, valid bit and registered compare flags
// depends on slt_pkg
module slt_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  slt_pkg::cell_ctrl_t ctrl,
    input  slt_pkg::value_t     left_value,
    input  logic                left_valid,
    input  logic                left_le,
    input  slt_pkg::value_t     right_value,
    input  logic                right_valid,
    output slt_pkg::value_t     value,
    output logic                valid,
    output logic                le,
    output logic                eq
);

    slt_pkg::value_t value_reg, value_next;
    logic            valid_reg, valid_next;
    logic            le_reg, le_next;
    logic            eq_reg, eq_next;

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        le_next    = le_reg;
        eq_next    = eq_reg;
        if (ctrl.capture)
        begin
            le_next = valid_reg && (value_reg <= ctrl.operand);
            eq_next = valid_reg && (value_reg == ctrl.operand);
        end
        if (ctrl.do_insert && !le_reg)
        begin
            if (left_le)
            begin
                // insertion point
                value_next = ctrl.operand;
                valid_next = 1'b1;
            end
            else
            begin
                value_next = left_value;
                valid_next = left_valid;
            end
        end
        // at or past the first equal entry: close the gap
        if (ctrl.do_delete && valid_reg && (!le_reg || eq_reg))
        begin
            value_next = right_value;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            le_reg    <= 1'b0;
            eq_reg    <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            le_reg    <= le_next;
            eq_reg    <= eq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;
    assign le    = le_reg;
    assign eq    = eq_reg;

endmodule

FILE: design/sorted_list_table_core.sv
// top level of the sorted list table: sequencer, chain of slot cells, result register
// depends on slt_pkg, slt_req_if, slt_rsp_if, slt_cell
//
// Holds up to CAPACITY signed 32-bit values in ascending order in a row of cells,
// one value per cell. Each request transfer is an insert, delete or search; each
// produces exactly one response transfer with status, 1-based match position (search
// only) and the count held afterwards. From request transfer to a loaded response
// an item goes through these steps in order: the operand is latched, every cell
// compares its value against it and registers its flags, and the cells shift left
// or right through their neighbors while the response register loads. The next
// request is taken in the cycle after the update, so no new item is accepted before
// the last one is through; a response left waiting stalls only the update cycle of
// the following item. Position and count are five bits wide and wrap for capacities
// above 31. No clearing pass is needed after reset: the valid bits reset at once.
module sorted_list_table_core #(
    parameter int CAPACITY = slt_pkg::CAPACITY_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    slt_req_if.sink          req,
    slt_rsp_if.source        rsp
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int WW = (CW > slt_pkg::COUNT_W) ? CW : slt_pkg::COUNT_W;

    slt_pkg::state_t state_reg, state_next;

    // latched request
    logic [1:0]      op_reg;
    slt_pkg::value_t val_reg;

    logic [CW-1:0] count_reg, count_next;

    // response register
    logic                        rsp_valid_reg, rsp_valid_next;
    slt_pkg::status_t            status_reg, status_next;
    logic [slt_pkg::POS_W-1:0]   position_reg, position_next;

    // cell row
    slt_pkg::cell_ctrl_t ctrl;
    slt_pkg::value_t     cell_value [CAPACITY];
    logic [CAPACITY-1:0] cell_valid;
    logic [CAPACITY-1:0] cell_le;
    logic [CAPACITY-1:0] cell_eq;

    logic          req_xfer;
    logic          rsp_free;
    logic          apply;
    logic          full;
    logic          empty;
    logic          found;
    logic [CW-1:0] match_pos;
    logic [WW-1:0] pos_wide;
    logic [WW-1:0] count_wide;

    assign req_xfer = req.valid && req.ready;
    assign rsp_free = !rsp_valid_reg || rsp.ready;
    assign apply    = (state_reg == slt_pkg::ST_APPLY) && rsp_free;
    assign full     = (count_reg == CW'(CAPACITY));
    assign empty    = (count_reg == '0);
    assign found    = |cell_eq;

    // first equal entry: equal entries are contiguous, so it is the one whose left
    // neighbor is not equal; position is its index plus one
    always_comb
    begin
        match_pos = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (cell_eq[i] && (i == 0 || !cell_eq[(i == 0) ? 0 : i - 1]))
            begin
                match_pos = match_pos | CW'(i + 1);
            end
        end
    end

    // broadcast to the cells
    always_comb
    begin
        ctrl.capture   = (state_reg == slt_pkg::ST_CMP);
        ctrl.operand   = val_reg;
        ctrl.do_insert = apply && (op_reg == slt_pkg::ACT_INSERT) && !full;
        ctrl.do_delete = apply && (op_reg == slt_pkg::ACT_DELETE) && found;
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            slt_pkg::value_t lv;
            logic            lval;
            logic            lle;
            slt_pkg::value_t rv;
            logic            rval;

            if (g == 0)
            begin : g_first
                // leftmost cell: a virtual neighbor that always compares at or below the operand
                assign lv   = '0;
                assign lval = 1'b0;
                assign lle  = 1'b1;
            end
            else
            begin : g_mid_left
                assign lv   = cell_value[g-1];
                assign lval = cell_valid[g-1];
                assign lle  = cell_le[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_last
                assign rv   = '0;
                assign rval = 1'b0;
            end
            else
            begin : g_mid_right
                assign rv   = cell_value[g+1];
                assign rval = cell_valid[g+1];
            end

            slt_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .left_value  (lv),
                .left_valid  (lval),
                .left_le     (lle),
                .right_value (rv),
                .right_valid (rval),
                .value       (cell_value[g]),
                .valid       (cell_valid[g]),
                .le          (cell_le[g]),
                .eq          (cell_eq[g])
            );
        end
    endgenerate

    // sequencer, count and response
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg;
        status_next    = status_reg;
        position_next  = position_reg;
        pos_wide       = WW'(match_pos);

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            slt_pkg::ST_IDLE:
            begin
                if (req_xfer)
                begin
                    state_next = slt_pkg::ST_CMP;
                end
            end
            slt_pkg::ST_CMP:
            begin
                state_next = slt_pkg::ST_APPLY;
            end
            slt_pkg::ST_APPLY:
            begin
                if (rsp_free)
                begin
                    state_next     = slt_pkg::ST_IDLE;
                    rsp_valid_next = 1'b1;
                    status_next    = slt_pkg::STS_DONE;
                    position_next  = '0;
                    case (op_reg)
                        slt_pkg::ACT_INSERT:
                        begin
                            if (full)
                            begin
                                status_next = slt_pkg::STS_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + CW'(1);
                            end
                        end
                        slt_pkg::ACT_DELETE,
                        slt_pkg::ACT_SEARCH:
                        begin
                            if (empty)
                            begin
                                status_next = slt_pkg::STS_EMPTY;
                            end
                            else if (!found)
                            begin
                                status_next = slt_pkg::STS_NOT_FOUND;
                            end
                            else if (op_reg == slt_pkg::ACT_SEARCH)
                            begin
                                position_next = pos_wide[slt_pkg::POS_W-1:0];
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                        default:
                        begin
                            // unused action code: no operation
                            status_next = slt_pkg::STS_DONE;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = slt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= slt_pkg::ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            op_reg  <= req.action;
            val_reg <= req.value;
        end
        status_reg   <= status_next;
        position_reg <= position_next;
    end

    assign count_wide      = WW'(count_reg);
    assign req.ready       = (state_reg == slt_pkg::ST_IDLE);
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.position    = position_reg;
    assign rsp.entry_count = count_wide[slt_pkg::COUNT_W-1:0];

    // count never runs past the number of cells
    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("held count exceeds capacity");

    // valid cells always match the held count
    a_valid_count : assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cell_valid) == int'(count_reg))
        else $error("valid cells disagree with held count");

    // a nonzero position only comes with a successful search
    a_pos_done : assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && (position_reg != '0) |-> (status_reg == slt_pkg::STS_DONE))
        else $error("position reported on a failed operation");

    // a loaded response comes out of the update cycle
    a_rsp_source : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg) == slt_pkg::ST_APPLY)
        else $error("response loaded outside the update cycle");

endmodule
